/* rtl/core/lc3d_pkg.sv */
// lc3d_pkg: opcode codes, control field codes and the decoded control record
// shared by the lc3 instruction decoder modules
// no dependencies
package lc3d_pkg;

  localparam int unsigned OutW  = 56;

  typedef enum logic [3:0] {
    OPC_BR   = 4'd0,
    OPC_ADD  = 4'd1,
    OPC_LD   = 4'd2,
    OPC_ST   = 4'd3,
    OPC_JSR  = 4'd4,
    OPC_AND  = 4'd5,
    OPC_LDR  = 4'd6,
    OPC_STR  = 4'd7,
    OPC_RTI  = 4'd8,
    OPC_NOT  = 4'd9,
    OPC_LDI  = 4'd10,
    OPC_STI  = 4'd11,
    OPC_JMP  = 4'd12,
    OPC_RES  = 4'd13,
    OPC_LEA  = 4'd14,
    OPC_TRAP = 4'd15
  } opcode_t;

  localparam logic [1:0] ALU_PASS = 2'd0;
  localparam logic [1:0] ALU_ADD  = 2'd1;
  localparam logic [1:0] ALU_AND  = 2'd2;
  localparam logic [1:0] ALU_NOT  = 2'd3;

  localparam logic [1:0] SEL_A_PC  = 2'b01;
  localparam logic [1:0] SEL_B_IMM = 2'b10;

  localparam logic [2:0] FMT_NONE  = 3'd0;
  localparam logic [2:0] FMT_IMM5  = 3'd1;
  localparam logic [2:0] FMT_OFF6  = 3'd2;
  localparam logic [2:0] FMT_OFF9  = 3'd3;
  localparam logic [2:0] FMT_OFF11 = 3'd4;

  localparam logic [1:0] PCU_SEQ  = 2'd0;
  localparam logic [1:0] PCU_BR   = 2'd1;
  localparam logic [1:0] PCU_CALL = 2'd2;
  localparam logic [1:0] PCU_JUMP = 2'd3;

  localparam logic [1:0] WB_ALU = 2'd0;
  localparam logic [1:0] WB_MEM = 2'd1;
  localparam logic [1:0] WB_PC  = 2'd2;

  localparam logic [3:0] EN_REG = 4'b0001;
  localparam logic [3:0] EN_MRD = 4'b0010;
  localparam logic [3:0] EN_MWR = 4'b0100;
  localparam logic [3:0] EN_CC  = 4'b1000;

  localparam logic [7:0] HALT_VECTOR = 8'h25;
  localparam logic [2:0] LINK_REG    = 3'd7;

  typedef struct packed {
    logic [2:0]  use_flags;
    logic [2:0]  br_nzp;
    logic [15:0] immediate;
    logic [8:0]  register_numbers;
    logic [3:0]  enables;
    logic [1:0]  writeback_source;
    logic [1:0]  pc_update;
    logic [2:0]  imm_format;
    logic [1:0]  operand_select;
    logic [1:0]  alu_op;
    logic [3:0]  opcode;
  } ctrl_t;

endpackage

/* rtl/core/lc3_instruction_decoder.sv */
// lc3_instruction_decoder: top level, input register, decode logic, result register
// depends on lc3d_pkg and lc3d_decode
//
// usage:
//   in channel carries one 16-bit instruction word per transfer on in_tdata.
//   out channel carries the decoded controls on out_tdata, one result per
//   instruction, in order.
//   an instruction is registered on transfer, decoded by the combinational
//   decode logic and captured in the result register; out_tvalid rises when
//   the result register is loaded, and the result leaves on out_tready high.
//   throughput is one instruction per cycle, set by the two register stages
//   that both advance every cycle while out_tready is high.
//   when the receiver stalls, the result register holds, the input register
//   fills, and in_tready drops once both hold an item; no item is lost.
//   in_tready depends combinationally on out_tready through the stage enable.
//   reset (rst_n low, synchronous) empties both stages; no result is pending
//   afterwards. the block has no other state.
module lc3_instruction_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] instruction
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [3:0] opcode, [5:4] alu_op, [7:6] operand_select,
                                  // [10:8] imm_format, [12:11] pc_update,
                                  // [14:13] writeback_source, [18:15] enables,
                                  // [27:19] register_numbers, [43:28] immediate,
                                  // [46:44] br_nzp, [49:47] use_flags,
                                  // [55:50] zero
);

  logic            s1_valid_r;
  logic [15:0]     ins_r;
  logic            out_valid_r;
  lc3d_pkg::ctrl_t ctrl_r;
  lc3d_pkg::ctrl_t ctrl_nxt;
  logic            out_adv;
  logic            s1_adv;

  assign out_adv   = !out_valid_r || out_tready;
  assign s1_adv    = !s1_valid_r || out_adv;
  assign in_tready = s1_adv;

  lc3d_decode u_decode (
    .ins  (ins_r),
    .ctrl (ctrl_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_tvalid) begin
      ins_r <= in_tdata;
    end
    if (out_adv && s1_valid_r) begin
      ctrl_r <= ctrl_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(lc3d_pkg::OutW - $bits(lc3d_pkg::ctrl_t)){1'b0}}, ctrl_r};

`ifndef SYNTHESIS
  a_halt_only_trap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ctrl_r.use_flags[2] |-> ctrl_r.opcode == lc3d_pkg::OPC_TRAP)
    else $error("halt raised for a non-trap opcode");

  a_no_imm_without_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ctrl_r.imm_format == lc3d_pkg::FMT_NONE |-> ctrl_r.immediate == 16'd0)
    else $error("immediate present without a format");

  a_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(ctrl_r.enables[0] && ctrl_r.enables[2]))
    else $error("register write and memory write together");

  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_adv |=> out_valid_r)
    else $error("decoded item dropped between stages");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_adv |=> s1_valid_r && $stable(ins_r))
    else $error("input register changed while stalled");
`endif

endmodule

/* rtl/core/lc3d_decode.sv */
// lc3d_decode: combinational decode of one instruction word into controls
// depends on lc3d_pkg
module lc3d_decode (
  input  logic [15:0]    ins,
  output lc3d_pkg::ctrl_t ctrl
);

  function automatic logic [15:0] sext5(input logic [4:0] v);
    sext5 = {{11{v[4]}}, v};
  endfunction

  function automatic logic [15:0] sext6(input logic [5:0] v);
    sext6 = {{10{v[5]}}, v};
  endfunction

  function automatic logic [15:0] sext9(input logic [8:0] v);
    sext9 = {{7{v[8]}}, v};
  endfunction

  function automatic logic [15:0] sext11(input logic [10:0] v);
    sext11 = {{5{v[10]}}, v};
  endfunction

  lc3d_pkg::opcode_t op;
  logic [2:0] r96;
  logic [2:0] r63;
  logic [2:0] s1;
  logic [2:0] s2;
  logic [2:0] dst;
  logic       u1;
  logic       u2;
  logic       halt;

  assign op  = lc3d_pkg::opcode_t'(ins[15:12]);
  assign r96 = ins[11:9];
  assign r63 = ins[8:6];

  always_comb begin
    ctrl = '0;
    s1   = '0;
    s2   = '0;
    dst  = '0;
    u1   = 1'b0;
    u2   = 1'b0;
    halt = 1'b0;
    ctrl.opcode = ins[15:12];
    unique case (op)
      lc3d_pkg::OPC_BR: begin
        ctrl.immediate      = sext9(ins[8:0]);
        ctrl.br_nzp         = r96;
        ctrl.alu_op         = lc3d_pkg::ALU_ADD;
        ctrl.operand_select = lc3d_pkg::SEL_A_PC | lc3d_pkg::SEL_B_IMM;
        ctrl.imm_format     = lc3d_pkg::FMT_OFF9;
        ctrl.pc_update      = lc3d_pkg::PCU_BR;
      end
      lc3d_pkg::OPC_ADD, lc3d_pkg::OPC_AND: begin
        s1  = r63;
        dst = r96;
        u1  = 1'b1;
        if (ins[5]) begin
          ctrl.immediate      = sext5(ins[4:0]);
          ctrl.imm_format     = lc3d_pkg::FMT_IMM5;
          ctrl.operand_select = lc3d_pkg::SEL_B_IMM;
        end else begin
          s2 = ins[2:0];
          u2 = 1'b1;
        end
        ctrl.alu_op  = (op == lc3d_pkg::OPC_ADD) ? lc3d_pkg::ALU_ADD : lc3d_pkg::ALU_AND;
        ctrl.enables = lc3d_pkg::EN_REG | lc3d_pkg::EN_CC;
      end
      lc3d_pkg::OPC_LD: begin
        dst                   = r96;
        ctrl.immediate        = sext9(ins[8:0]);
        ctrl.alu_op           = lc3d_pkg::ALU_ADD;
        ctrl.operand_select   = lc3d_pkg::SEL_A_PC | lc3d_pkg::SEL_B_IMM;
        ctrl.imm_format       = lc3d_pkg::FMT_OFF9;
        ctrl.writeback_source = lc3d_pkg::WB_MEM;
        ctrl.enables          = lc3d_pkg::EN_REG | lc3d_pkg::EN_MRD | lc3d_pkg::EN_CC;
      end
      lc3d_pkg::OPC_ST: begin
        s2                  = r96;
        u2                  = 1'b1;
        ctrl.immediate      = sext9(ins[8:0]);
        ctrl.alu_op         = lc3d_pkg::ALU_ADD;
        ctrl.operand_select = lc3d_pkg::SEL_A_PC | lc3d_pkg::SEL_B_IMM;
        ctrl.imm_format     = lc3d_pkg::FMT_OFF9;
        ctrl.enables        = lc3d_pkg::EN_MWR;
      end
      lc3d_pkg::OPC_LDR: begin
        s1                    = r63;
        dst                   = r96;
        u1                    = 1'b1;
        ctrl.immediate        = sext6(ins[5:0]);
        ctrl.alu_op           = lc3d_pkg::ALU_ADD;
        ctrl.operand_select   = lc3d_pkg::SEL_B_IMM;
        ctrl.imm_format       = lc3d_pkg::FMT_OFF6;
        ctrl.writeback_source = lc3d_pkg::WB_MEM;
        ctrl.enables          = lc3d_pkg::EN_REG | lc3d_pkg::EN_MRD | lc3d_pkg::EN_CC;
      end
      lc3d_pkg::OPC_STR: begin
        s1                  = r63;
        s2                  = r96;
        u1                  = 1'b1;
        u2                  = 1'b1;
        ctrl.immediate      = sext6(ins[5:0]);
        ctrl.alu_op         = lc3d_pkg::ALU_ADD;
        ctrl.operand_select = lc3d_pkg::SEL_B_IMM;
        ctrl.imm_format     = lc3d_pkg::FMT_OFF6;
        ctrl.enables        = lc3d_pkg::EN_MWR;
      end
      lc3d_pkg::OPC_NOT: begin
        s1           = r63;
        dst          = r96;
        u1           = 1'b1;
        ctrl.alu_op  = lc3d_pkg::ALU_NOT;
        ctrl.enables = lc3d_pkg::EN_REG | lc3d_pkg::EN_CC;
      end
      lc3d_pkg::OPC_JSR: begin
        dst                   = lc3d_pkg::LINK_REG;
        ctrl.pc_update        = lc3d_pkg::PCU_CALL;
        ctrl.writeback_source = lc3d_pkg::WB_PC;
        ctrl.enables          = lc3d_pkg::EN_REG;
        if (ins[11]) begin
          ctrl.immediate      = sext11(ins[10:0]);
          ctrl.alu_op         = lc3d_pkg::ALU_ADD;
          ctrl.operand_select = lc3d_pkg::SEL_A_PC | lc3d_pkg::SEL_B_IMM;
          ctrl.imm_format     = lc3d_pkg::FMT_OFF11;
        end else begin
          s1 = r63;
          u1 = 1'b1;
        end
      end
      lc3d_pkg::OPC_JMP: begin
        s1             = r63;
        u1             = 1'b1;
        ctrl.pc_update = lc3d_pkg::PCU_JUMP;
      end
      lc3d_pkg::OPC_LEA: begin
        dst                 = r96;
        ctrl.immediate      = sext9(ins[8:0]);
        ctrl.alu_op         = lc3d_pkg::ALU_ADD;
        ctrl.operand_select = lc3d_pkg::SEL_A_PC | lc3d_pkg::SEL_B_IMM;
        ctrl.imm_format     = lc3d_pkg::FMT_OFF9;
        ctrl.enables        = lc3d_pkg::EN_REG | lc3d_pkg::EN_CC;
      end
      lc3d_pkg::OPC_TRAP: begin
        halt = (ins[7:0] == lc3d_pkg::HALT_VECTOR);
      end
      default: begin
      end
    endcase
    ctrl.register_numbers = {dst, s2, s1};
    ctrl.use_flags        = {halt, u2, u1};
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: stream testbench for lc3_instruction_decoder, directed and random instruction words
// with random idling on both channels, every result checked against a built-in decoder
// depends on lc3d_pkg and lc3_instruction_decoder
module tb_top;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  logic [15:0]     instr_queue[$];
  lc3d_pkg::ctrl_t ctrl_expected[$];
  int          n_words        = 0;
  int          words_accepted = 0;
  int          results_seen   = 0;
  int          mismatch_count = 0;
  logic        in_xfer        = 1'b0;
  logic        hold_off       = 1'b0;
  int          send_gap       = 0;
  int          send_calm      = 0;
  int          stall_left     = 0;
  int          recv_calm      = 0;

  lc3_instruction_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [15:0] instruction
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)     // [3:0] opcode ... [49:47] use_flags, [55:50] zero
  );

  always #5 clk = ~clk;

  function automatic lc3d_pkg::ctrl_t predict_ctrl(logic [15:0] ins);
    lc3d_pkg::ctrl_t c;
    logic [2:0] s1;
    logic [2:0] s2;
    logic [2:0] dst;
    logic       u1;
    logic       u2;
    logic       halt;
    c    = '0;
    s1   = '0;
    s2   = '0;
    dst  = '0;
    u1   = 1'b0;
    u2   = 1'b0;
    halt = 1'b0;
    c.opcode = ins[15:12];
    case (lc3d_pkg::opcode_t'(ins[15:12]))
      lc3d_pkg::OPC_BR: begin
        c.immediate      = {{7{ins[8]}}, ins[8:0]};
        c.br_nzp         = ins[11:9];
        c.alu_op         = lc3d_pkg::ALU_ADD;
        c.operand_select = lc3d_pkg::SEL_A_PC | lc3d_pkg::SEL_B_IMM;
        c.imm_format     = lc3d_pkg::FMT_OFF9;
        c.pc_update      = lc3d_pkg::PCU_BR;
      end
      lc3d_pkg::OPC_ADD, lc3d_pkg::OPC_AND: begin
        s1  = ins[8:6];
        dst = ins[11:9];
        u1  = 1'b1;
        if (ins[5]) begin
          c.immediate      = {{11{ins[4]}}, ins[4:0]};
          c.imm_format     = lc3d_pkg::FMT_IMM5;
          c.operand_select = lc3d_pkg::SEL_B_IMM;
        end else begin
          s2 = ins[2:0];
          u2 = 1'b1;
        end
        c.alu_op  = (ins[15:12] == lc3d_pkg::OPC_ADD) ? lc3d_pkg::ALU_ADD : lc3d_pkg::ALU_AND;
        c.enables = lc3d_pkg::EN_REG | lc3d_pkg::EN_CC;
      end
      lc3d_pkg::OPC_LD: begin
        dst                = ins[11:9];
        c.immediate        = {{7{ins[8]}}, ins[8:0]};
        c.alu_op           = lc3d_pkg::ALU_ADD;
        c.operand_select   = lc3d_pkg::SEL_A_PC | lc3d_pkg::SEL_B_IMM;
        c.imm_format       = lc3d_pkg::FMT_OFF9;
        c.writeback_source = lc3d_pkg::WB_MEM;
        c.enables          = lc3d_pkg::EN_REG | lc3d_pkg::EN_MRD | lc3d_pkg::EN_CC;
      end
      lc3d_pkg::OPC_ST: begin
        s2               = ins[11:9];
        u2               = 1'b1;
        c.immediate      = {{7{ins[8]}}, ins[8:0]};
        c.alu_op         = lc3d_pkg::ALU_ADD;
        c.operand_select = lc3d_pkg::SEL_A_PC | lc3d_pkg::SEL_B_IMM;
        c.imm_format     = lc3d_pkg::FMT_OFF9;
        c.enables        = lc3d_pkg::EN_MWR;
      end
      lc3d_pkg::OPC_LDR: begin
        s1                 = ins[8:6];
        dst                = ins[11:9];
        u1                 = 1'b1;
        c.immediate        = {{10{ins[5]}}, ins[5:0]};
        c.alu_op           = lc3d_pkg::ALU_ADD;
        c.operand_select   = lc3d_pkg::SEL_B_IMM;
        c.imm_format       = lc3d_pkg::FMT_OFF6;
        c.writeback_source = lc3d_pkg::WB_MEM;
        c.enables          = lc3d_pkg::EN_REG | lc3d_pkg::EN_MRD | lc3d_pkg::EN_CC;
      end
      lc3d_pkg::OPC_STR: begin
        s1               = ins[8:6];
        s2               = ins[11:9];
        u1               = 1'b1;
        u2               = 1'b1;
        c.immediate      = {{10{ins[5]}}, ins[5:0]};
        c.alu_op         = lc3d_pkg::ALU_ADD;
        c.operand_select = lc3d_pkg::SEL_B_IMM;
        c.imm_format     = lc3d_pkg::FMT_OFF6;
        c.enables        = lc3d_pkg::EN_MWR;
      end
      lc3d_pkg::OPC_NOT: begin
        s1        = ins[8:6];
        dst       = ins[11:9];
        u1        = 1'b1;
        c.alu_op  = lc3d_pkg::ALU_NOT;
        c.enables = lc3d_pkg::EN_REG | lc3d_pkg::EN_CC;
      end
      lc3d_pkg::OPC_JSR: begin
        dst                = lc3d_pkg::LINK_REG;
        c.pc_update        = lc3d_pkg::PCU_CALL;
        c.writeback_source = lc3d_pkg::WB_PC;
        c.enables          = lc3d_pkg::EN_REG;
        if (ins[11]) begin
          c.immediate      = {{5{ins[10]}}, ins[10:0]};
          c.alu_op         = lc3d_pkg::ALU_ADD;
          c.operand_select = lc3d_pkg::SEL_A_PC | lc3d_pkg::SEL_B_IMM;
          c.imm_format     = lc3d_pkg::FMT_OFF11;
        end else begin
          s1 = ins[8:6];
          u1 = 1'b1;
        end
      end
      lc3d_pkg::OPC_JMP: begin
        s1          = ins[8:6];
        u1          = 1'b1;
        c.pc_update = lc3d_pkg::PCU_JUMP;
      end
      lc3d_pkg::OPC_LEA: begin
        dst              = ins[11:9];
        c.immediate      = {{7{ins[8]}}, ins[8:0]};
        c.alu_op         = lc3d_pkg::ALU_ADD;
        c.operand_select = lc3d_pkg::SEL_A_PC | lc3d_pkg::SEL_B_IMM;
        c.imm_format     = lc3d_pkg::FMT_OFF9;
        c.enables        = lc3d_pkg::EN_REG | lc3d_pkg::EN_CC;
      end
      lc3d_pkg::OPC_TRAP: halt = (ins[7:0] == lc3d_pkg::HALT_VECTOR);
      default: ;
    endcase
    c.register_numbers = {dst, s2, s1};
    c.use_flags        = {halt, u2, u1};
    return c;
  endfunction

  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic check_field(string name, logic [15:0] exp, logic [15:0] act);
    if (act !== exp) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      mismatch_count++;
    end
  endtask

  task automatic check_result(lc3d_pkg::ctrl_t exp, logic [55:0] act_bus);
    lc3d_pkg::ctrl_t act;
    act = act_bus[49:0];
    check_field("opcode", 16'(exp.opcode), 16'(act.opcode));
    check_field("alu_op", 16'(exp.alu_op), 16'(act.alu_op));
    check_field("operand_select", 16'(exp.operand_select), 16'(act.operand_select));
    check_field("imm_format", 16'(exp.imm_format), 16'(act.imm_format));
    check_field("pc_update", 16'(exp.pc_update), 16'(act.pc_update));
    check_field("writeback_source", 16'(exp.writeback_source), 16'(act.writeback_source));
    check_field("enables", 16'(exp.enables), 16'(act.enables));
    check_field("register_numbers", 16'(exp.register_numbers), 16'(act.register_numbers));
    check_field("immediate", exp.immediate, act.immediate);
    check_field("br_nzp", 16'(exp.br_nzp), 16'(act.br_nzp));
    check_field("use_flags", 16'(exp.use_flags), 16'(act.use_flags));
    check_field("pad", '0, 16'(act_bus[55:50]));
  endtask

  // instruction driver
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_xfer)) begin
      if (send_gap > 0) begin
        send_gap  <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (instr_queue.size() > 0) begin
        in_tdata  <= instr_queue.pop_front();
        in_tvalid <= 1'b1;
        if (send_calm > 0) send_calm <= send_calm - 1;
        else if ($urandom_range(0, 99) < 2) send_calm <= $urandom_range(20, 80);
        else if ($urandom_range(0, 99) < 30) send_gap <= idle_length();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (recv_calm > 0) recv_calm <= recv_calm - 1;
      else if ($urandom_range(0, 99) < 2) recv_calm <= $urandom_range(20, 80);
      else if ($urandom_range(0, 99) < 25) stall_left <= idle_length();
    end
  end

  // transfer monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (ctrl_expected.size() == 0) begin
          $error("out_tdata: expected nothing, got %0h", out_tdata);
          mismatch_count++;
        end else begin
          check_result(ctrl_expected.pop_front(), out_tdata);
        end
      end
      if (in_tvalid && in_tready) begin
        ctrl_expected.push_back(predict_ctrl(in_tdata));
        words_accepted <= words_accepted + 1;
      end
    end
  end

  // long receiver hold-offs so the block fills and drops in_tready
  initial begin
    wait (results_seen >= 100);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (80) @(posedge clk);
    hold_off = 1'b0;
    wait (results_seen >= 300);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (60) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    logic [15:0] word;
    // field extremes, every opcode, both jsr forms, halt and near-halt traps
    instr_queue.push_back({lc3d_pkg::OPC_BR,   12'h000});
    instr_queue.push_back({lc3d_pkg::OPC_TRAP, 12'hFFF});
    instr_queue.push_back({lc3d_pkg::OPC_BR,   12'hFFF});
    instr_queue.push_back({lc3d_pkg::OPC_BR,   12'hF00});
    instr_queue.push_back({lc3d_pkg::OPC_ADD,  12'h0BF});
    instr_queue.push_back({lc3d_pkg::OPC_ADD,  12'hE87});
    instr_queue.push_back({lc3d_pkg::OPC_AND,  12'hFFF});
    instr_queue.push_back({lc3d_pkg::OPC_AND,  12'h030});
    instr_queue.push_back({lc3d_pkg::OPC_LD,   12'hFFF});
    instr_queue.push_back({lc3d_pkg::OPC_ST,   12'h100});
    instr_queue.push_back({lc3d_pkg::OPC_JSR,  12'hC00});
    instr_queue.push_back({lc3d_pkg::OPC_JSR,  12'hBFF});
    instr_queue.push_back({lc3d_pkg::OPC_JSR,  12'h1C0});
    instr_queue.push_back({lc3d_pkg::OPC_LDR,  12'hFE0});
    instr_queue.push_back({lc3d_pkg::OPC_STR,  12'hE1F});
    instr_queue.push_back({lc3d_pkg::OPC_RTI,  12'h000});
    instr_queue.push_back({lc3d_pkg::OPC_NOT,  12'hFFF});
    instr_queue.push_back({lc3d_pkg::OPC_LDI,  12'hFFF});
    instr_queue.push_back({lc3d_pkg::OPC_STI,  12'hFFF});
    instr_queue.push_back({lc3d_pkg::OPC_JMP,  12'h1C0});
    instr_queue.push_back({lc3d_pkg::OPC_RES,  12'hFFF});
    instr_queue.push_back({lc3d_pkg::OPC_LEA,  12'hE00});
    instr_queue.push_back({lc3d_pkg::OPC_TRAP, 4'h0, lc3d_pkg::HALT_VECTOR});
    instr_queue.push_back({lc3d_pkg::OPC_TRAP, 4'hF, lc3d_pkg::HALT_VECTOR});
    instr_queue.push_back({lc3d_pkg::OPC_TRAP, 4'h0, 8'h24});
    for (int i = 0; i < 500; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        word = {lc3d_pkg::OPC_TRAP, 4'($urandom_range(0, 15)), lc3d_pkg::HALT_VECTOR};
      end else begin
        word = 16'($urandom_range(0, 65535));
      end
      instr_queue.push_back(word);
    end
    n_words = instr_queue.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (words_accepted < n_words || ctrl_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* lc3_instruction_decoder.f */
rtl/core/lc3d_pkg.sv
rtl/core/lc3d_decode.sv
rtl/core/lc3_instruction_decoder.sv
dv/tb_top.sv
